// File: rtl/lkct_pkg.sv
// ----------------------------------------------------------------------------
// lkct_pkg: shared types and constants
// Pixel type, configuration register indexes and fixed-point constants of the
// luminance keyed color tint.
// ----------------------------------------------------------------------------
package lkct_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  typedef enum logic [1:0] {
    CFG_TARGET_RED   = 2'd0,
    CFG_TARGET_GREEN = 2'd1,
    CFG_TARGET_BLUE  = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [7:0] TargetRedRst   = 8'd174;
  localparam logic [7:0] TargetGreenRst = 8'd72;
  localparam logic [7:0] TargetBlueRst  = 8'd255;

  localparam logic [15:0] WeightRed   = 16'd13933;
  localparam logic [15:0] WeightGreen = 16'd46871;
  localparam logic [15:0] WeightBlue  = 16'd4732;

  localparam logic [15:0] LowLuma           = 16'd6554;
  localparam logic [15:0] LowStrength       = 16'd6554;
  localparam logic [15:0] BaseStrength      = 16'd27525;
  localparam logic [15:0] SlopeStrength     = 16'd20972;
  localparam logic [15:0] MaxStrength       = 16'd48497;
  localparam logic [15:0] HighLuma          = 16'd53740;
  localparam logic [15:0] HighOneMinusKeep  = 16'd43254;
  localparam logic [15:0] NormOneMinusKeep  = 16'd60293;

  localparam logic [16:0] OneQ16 = 17'd65536;

  localparam int unsigned Latency = 5;

endpackage

// File: rtl/lkct_mix.sv
// ----------------------------------------------------------------------------
// lkct_mix: luminance and blend factor pipeline
// Four register stages: weighted sum, divide by 255, strength and keep
// selection, mix product. The pixel and its valid bit travel alongside.
// ----------------------------------------------------------------------------
module lkct_mix
  import lkct_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  pix_t        pix_i,
  output logic        valid_o,
  output pix_t        pix_o,
  output logic [15:0] mix_o
);

  logic [3:0]  valid_q;
  pix_t        pix1_q, pix2_q, pix3_q, pix4_q;

  logic [23:0] sum_d, sum_q;
  logic [55:0] recip;
  logic [15:0] luma_d, luma_q;
  logic [31:0] slope_prod;
  logic [15:0] strength_d, strength_q;
  logic [15:0] okeep_d, okeep_q;
  logic [31:0] mix_prod;
  logic [15:0] mix_d, mix_q;

  always_comb begin
    sum_d = 24'(WeightRed) * 24'(pix_i.red) + 24'(WeightGreen) * 24'(pix_i.green)
          + 24'(WeightBlue) * 24'(pix_i.blue);
  end

  // Divide by 255 via reciprocal 2^24 + 2^16 + 2^8 + 2 over 2^32
  always_comb begin
    recip = (56'(sum_q) << 24) + (56'(sum_q) << 16) + (56'(sum_q) << 8)
          + (56'(sum_q) << 1);
    luma_d = recip[48] ? 16'hFFFF : recip[47:32];
  end

  always_comb begin
    slope_prod = 32'(luma_q) * 32'(SlopeStrength);
    if (luma_q < LowLuma) begin
      strength_d = LowStrength;
    end else if (BaseStrength + slope_prod[31:16] > MaxStrength) begin
      strength_d = MaxStrength;
    end else begin
      strength_d = BaseStrength + slope_prod[31:16];
    end
    okeep_d = (luma_q > HighLuma) ? HighOneMinusKeep : NormOneMinusKeep;
  end

  always_comb begin
    mix_prod = 32'(strength_q) * 32'(okeep_q);
    mix_d    = mix_prod[31:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    luma_q     <= luma_d;
    strength_q <= strength_d;
    okeep_q    <= okeep_d;
    mix_q      <= mix_d;
    pix1_q     <= pix_i;
    pix2_q     <= pix1_q;
    pix3_q     <= pix2_q;
    pix4_q     <= pix3_q;
  end

  assign valid_o = valid_q[3];
  assign pix_o   = pix4_q;
  assign mix_o   = mix_q;

endmodule

// File: rtl/luminance_keyed_color_tint.sv
// ----------------------------------------------------------------------------
// luminance_keyed_color_tint: RGBA tint keyed on Rec.709 luminance
// Blends each color channel toward a programmable target color by a factor
// derived from the pixel's luminance; transparent pixels pass unchanged.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at each rising edge where start_i is high and busy_o
//   is low. busy_o stays low, so one pixel can enter every cycle.
//   The result appears on red_o, green_o, blue_o, alpha_o for one cycle with
//   done_o high. Results leave in request order, one per request.
//   Throughput is one pixel per clock; latency is set by the five register
//   stages: weighted sum, divide by 255, strength select, mix product, blend.
//   Target color registers are written through cfg_we_i, cfg_idx_i and
//   cfg_data_i; the user must write them only while no request is in flight,
//   which the block itself does not enforce. An unknown index is ignored.
//   Reset clears all valid bits and loads the target color 174, 72, 255.
//   The receiver cannot stall: done_o marks a result valid for one cycle.
// ----------------------------------------------------------------------------
module luminance_keyed_color_tint
  import lkct_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  input  logic [7:0]         alpha_i,
  output logic               done_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [7:0]         alpha_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_data_i
);

  logic [7:0]  target_red_q, target_green_q, target_blue_q;
  pix_t        pix_in;
  logic        mix_valid;
  pix_t        mix_pix;
  logic [15:0] mix;
  logic [16:0] inv_mix;
  logic [24:0] acc_red, acc_green, acc_blue;
  pix_t        out_d, out_q;
  logic        done_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_red_q   <= TargetRedRst;
      target_green_q <= TargetGreenRst;
      target_blue_q  <= TargetBlueRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TARGET_RED:   target_red_q   <= cfg_data_i;
        CFG_TARGET_GREEN: target_green_q <= cfg_data_i;
        CFG_TARGET_BLUE:  target_blue_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pix_in = '{red: red_i, green: green_i, blue: blue_i, alpha: alpha_i};

  lkct_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i & ~busy_o),
    .pix_i   (pix_in),
    .valid_o (mix_valid),
    .pix_o   (mix_pix),
    .mix_o   (mix)
  );

  always_comb begin
    inv_mix   = OneQ16 - 17'(mix);
    acc_red   = 25'(mix_pix.red) * 25'(inv_mix) + 25'(target_red_q) * 25'(mix);
    acc_green = 25'(mix_pix.green) * 25'(inv_mix) + 25'(target_green_q) * 25'(mix);
    acc_blue  = 25'(mix_pix.blue) * 25'(inv_mix) + 25'(target_blue_q) * 25'(mix);
    out_d.alpha = mix_pix.alpha;
    if (mix_pix.alpha == 8'd0) begin
      out_d.red   = mix_pix.red;
      out_d.green = mix_pix.green;
      out_d.blue  = mix_pix.blue;
    end else begin
      out_d.red   = acc_red[24]   ? 8'hFF : acc_red[23:16];
      out_d.green = acc_green[24] ? 8'hFF : acc_green[23:16];
      out_d.blue  = acc_blue[24]  ? 8'hFF : acc_blue[23:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= mix_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o  = done_q;
  assign red_o   = out_q.red;
  assign green_o = out_q.green;
  assign blue_o  = out_q.blue;
  assign alpha_o = out_q.alpha;

endmodule

// File: rtl/lkct_checker.sv
// ----------------------------------------------------------------------------
// lkct_checker: port-level checks for the color tint
// Checks fixed latency, result count and pass-through behavior as seen on
// the top level ports.
// ----------------------------------------------------------------------------
module lkct_checker
  import lkct_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic [7:0] alpha_i,
  input logic       done_o,
  input logic [7:0] red_o,
  input logic [7:0] green_o,
  input logic [7:0] blue_o,
  input logic [7:0] alpha_o
);

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency done_o)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##Latency !done_o)
    else $error("result without request");

  a_alpha_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency (alpha_o == $past(alpha_i, Latency)))
    else $error("alpha changed");

  a_transparent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && alpha_i == 8'd0) |-> ##Latency
      (red_o == $past(red_i, Latency) && green_o == $past(green_i, Latency)
       && blue_o == $past(blue_i, Latency)))
    else $error("transparent pixel changed");

endmodule

bind luminance_keyed_color_tint lkct_checker u_lkct_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .red_i   (red_i),
  .green_i (green_i),
  .blue_i  (blue_i),
  .alpha_i (alpha_i),
  .done_o  (done_o),
  .red_o   (red_o),
  .green_o (green_o),
  .blue_o  (blue_o),
  .alpha_o (alpha_o)
);

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for luminance_keyed_color_tint
// Drives RGBA pixel requests with random gaps and scoreboards every tinted
// pixel against a bit-exact fixed-point tint predictor. A short directed
// table covers transparent, black, white, single-channel and luminance
// threshold pixels. Random phases follow, each at its own target color,
// including the all-zero and all-ones extremes and a write to an unused
// register index.
// ----------------------------------------------------------------------------
module tb_top;
  import lkct_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;
  localparam int unsigned IdlePct    = 13;
  localparam int unsigned PhaseItems = 255;
  localparam int unsigned NumPhases  = 6;

  typedef struct packed {
    pix_t px;
    logic known;
    pix_t res;
  } tint_case_t;

  localparam tint_case_t DirCases [20] = '{
    '{'{8'd0,   8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0,   8'd0}},
    '{'{8'd255, 8'd255, 8'd255, 8'd0},   1'b1, '{8'd255, 8'd255, 8'd255, 8'd0}},
    '{'{8'd18,  8'd200, 8'd77,  8'd0},   1'b1, '{8'd18,  8'd200, 8'd77,  8'd0}},
    '{'{8'd0,   8'd0,   8'd0,   8'd255}, 1'b1, '{8'd16,  8'd6,   8'd23,  8'd255}},
    '{'{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, '{8'd215, 8'd165, 8'd255, 8'd255}},
    '{'{8'd0,   8'd0,   8'd0,   8'd1},   1'b1, '{8'd16,  8'd6,   8'd23,  8'd1}},
    '{'{8'd255, 8'd255, 8'd255, 8'd1},   1'b1, '{8'd215, 8'd165, 8'd255, 8'd1}},
    '{'{8'd255, 8'd0,   8'd0,   8'd255}, 1'b0, '0},
    '{'{8'd0,   8'd255, 8'd0,   8'd255}, 1'b0, '0},
    '{'{8'd0,   8'd0,   8'd255, 8'd255}, 1'b0, '0},
    '{'{8'd25,  8'd25,  8'd25,  8'd200}, 1'b0, '0},
    '{'{8'd26,  8'd26,  8'd26,  8'd200}, 1'b0, '0},
    '{'{8'd209, 8'd209, 8'd209, 8'd128}, 1'b0, '0},
    '{'{8'd210, 8'd210, 8'd210, 8'd128}, 1'b0, '0},
    '{'{8'd170, 8'd85,  8'd240, 8'd127}, 1'b0, '0},
    '{'{8'd128, 8'd128, 8'd128, 8'd255}, 1'b0, '0},
    '{'{8'd1,   8'd2,   8'd3,   8'd254}, 1'b0, '0},
    '{'{8'd254, 8'd253, 8'd252, 8'd64},  1'b0, '0},
    '{'{8'd170, 8'd170, 8'd170, 8'd0},   1'b1, '{8'd170, 8'd170, 8'd170, 8'd0}},
    '{'{8'd85,  8'd85,  8'd85,  8'd170}, 1'b0, '0}
  };

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               start_i    = 1'b0;
  pix_t               req_px     = '0;
  logic               cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i  = '0;
  logic [7:0]         cfg_data_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [7:0]         red_o;
  logic [7:0]         green_o;
  logic [7:0]         blue_o;
  logic [7:0]         alpha_o;

  pix_t        tinted_q[$];
  int unsigned err_cnt  = 0;
  bit          idle_en  = 1'b1;
  logic [7:0]  tgt_red   = TargetRedRst;
  logic [7:0]  tgt_green = TargetGreenRst;
  logic [7:0]  tgt_blue  = TargetBlueRst;

  luminance_keyed_color_tint DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .red_i      (req_px.red),
    .green_i    (req_px.green),
    .blue_i     (req_px.blue),
    .alpha_i    (req_px.alpha),
    .done_o     (done_o),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o),
    .alpha_o    (alpha_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] blend_channel(logic [7:0] c, logic [7:0] t,
                                               int unsigned mix);
    int unsigned acc;
    acc = (int'(c) * (32'd65536 - mix) + int'(t) * mix) >> 16;
    return (acc > 255) ? 8'd255 : acc[7:0];
  endfunction

  function automatic pix_t tint_pixel(pix_t p);
    int unsigned luma;
    int unsigned strength;
    int unsigned okeep;
    int unsigned mix;
    pix_t        q;
    q = p;
    if (p.alpha == 8'd0) return q;
    luma = (int'(WeightRed) * int'(p.red) + int'(WeightGreen) * int'(p.green)
            + int'(WeightBlue) * int'(p.blue)) / 255;
    if (luma > 65535) luma = 65535;
    if (luma < int'(LowLuma)) begin
      strength = LowStrength;
    end else begin
      strength = int'(BaseStrength) + ((luma * int'(SlopeStrength)) >> 16);
      if (strength > int'(MaxStrength)) strength = MaxStrength;
    end
    okeep = (luma > int'(HighLuma)) ? int'(HighOneMinusKeep) : int'(NormOneMinusKeep);
    mix = (strength * okeep) >> 16;
    q.red   = blend_channel(p.red,   tgt_red,   mix);
    q.green = blend_channel(p.green, tgt_green, mix);
    q.blue  = blend_channel(p.blue,  tgt_blue,  mix);
    return q;
  endfunction

  function automatic pix_t rand_pixel();
    pix_t        p;
    int unsigned roll;
    logic [7:0]  v;
    roll = $urandom_range(0, 99);
    p.red   = 8'($urandom);
    p.green = 8'($urandom);
    p.blue  = 8'($urandom);
    p.alpha = 8'($urandom_range(1, 255));
    if (roll < 10) begin
      p.alpha = 8'd0;
    end else if (roll < 25) begin
      v = $urandom_range(0, 1) ? 8'($urandom_range(20, 32)) : 8'($urandom_range(202, 216));
      p.red   = v;
      p.green = v;
      p.blue  = v;
    end else if (roll < 35) begin
      p.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      p.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      p.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      if ($urandom_range(0, 1)) p.alpha = $urandom_range(0, 1) ? 8'd255 : 8'd1;
    end
    return p;
  endfunction

  task automatic check_pixel(pix_t want, pix_t got);
    string lane [4] = '{"red", "green", "blue", "alpha"};
    for (int k = 0; k < 4; k++) begin
      if (want[31-8*k -: 8] !== got[31-8*k -: 8]) begin
        $display("%0t: %s expected %0d got %0d", $time, lane[k],
                 want[31-8*k -: 8], got[31-8*k -: 8]);
        err_cnt++;
      end
    end
  endtask

  task automatic send_pixel(pix_t p, pix_t want);
    while (idle_en && $urandom_range(0, 99) < IdlePct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_px  <= p;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    tinted_q.push_back(want);
  endtask

  task automatic drain_pipe();
    start_i <= 1'b0;
    while (tinted_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic program_targets(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [CfgIdxW-1:0] idx [4];
    logic [7:0]         val [4];
    idx = '{CfgIdxW'(CFG_TARGET_RED), CfgIdxW'(CFG_TARGET_GREEN),
            CfgIdxW'(CFG_TARGET_BLUE), CfgIdxUnused};
    val = '{r, g, b, 8'($urandom)};
    for (int k = 0; k < 4; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[k];
      cfg_data_i <= val[k];
      @(posedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    tgt_red   = r;
    tgt_green = g;
    tgt_blue  = b;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (tinted_q.size() == 0) begin
        $display("%0t: unexpected pixel %0d %0d %0d %0d", $time,
                 red_o, green_o, blue_o, alpha_o);
        err_cnt++;
      end else begin
        check_pixel(tinted_q.pop_front(), {red_o, green_o, blue_o, alpha_o});
      end
    end
  end

  initial begin
    pix_t px;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (DirCases[i]) begin
      send_pixel(DirCases[i].px,
                 DirCases[i].known ? DirCases[i].res : tint_pixel(DirCases[i].px));
    end
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_pipe();
      case (ph)
        0: program_targets(8'd0, 8'd0, 8'd0);
        1: program_targets(8'd255, 8'd255, 8'd255);
        default: program_targets(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      idle_en = (ph != 1);
      repeat (PhaseItems) begin
        px = rand_pixel();
        send_pixel(px, tint_pixel(px));
      end
    end
    drain_pipe();
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
